/* rtl/bfa_pkg.sv */
`default_nettype none

package bfa_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int DW          = 32;
    localparam int AW          = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW          = $clog2(MAX_REGIONS + 1);

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef logic [DW-1:0] word_t;
    typedef logic [AW-1:0] idx_t;
    typedef logic [CW-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        word_t size;
        word_t start;
    } region_t;

    localparam int RW = $bits(region_t);

    typedef struct packed {
        logic  mode;
        word_t region_start;
        word_t amount;
    } req_t;

    typedef struct packed {
        status_t status;
        word_t   granted_start;
        word_t   leftover_start;
        word_t   leftover_size;
    } rsp_t;

endpackage

`default_nettype wire

/* rtl/bfa_req_if.sv */
`default_nettype none

interface bfa_req_if;
    import bfa_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/bfa_rsp_if.sv */
`default_nettype none

interface bfa_rsp_if;
    import bfa_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/bfa_ram.sv */
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/bfa_cmp_sub.sv */
`default_nettype none

module bfa_cmp_sub (
    input  wire bfa_pkg::word_t a,
    input  wire bfa_pkg::word_t b,
    output bfa_pkg::word_t      diff,
    output logic                borrow
);
    import bfa_pkg::*;

    logic [DW:0] wide;

    assign wide   = {1'b0, a} - {1'b0, b};
    assign diff   = wide[DW-1:0];
    assign borrow = wide[DW];

endmodule

`default_nettype wire

/* rtl/best_fit_allocator.sv */
// Add: sifts the entries above the insert slot up by one; a full table goes straight to the result.
// Allocate: scans up from index 0 to the fit at index p (the whole table with no fit), then
// closes the gap (exact fit) or sifts the remainder down to slot q.
// Not ready during the op; ready again with the result.
// One item at a time; the table RAM read port and one compare-subtract set it.
// Reset (async, active low) empties the table; table contents need no clearing.
`default_nettype none

module best_fit_allocator (
    input  wire logic clk,
    input  wire logic rst_n,
    bfa_req_if.sink   req,
    bfa_rsp_if.source rsp
);
    import bfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE,
        S_SIFT_START,
        S_SIFT,
        S_FIN
    } state_t;

    state_t  state_reg, state_next;
    logic    mode_reg, mode_next;
    word_t   amount_reg, amount_next;
    word_t   key_size_reg, key_size_next;
    word_t   key_start_reg, key_start_next;
    cnt_t    e_reg, e_next;
    cnt_t    hi_reg, hi_next;
    cnt_t    count_reg, count_next;
    status_t status_reg, status_next;
    word_t   granted_reg, granted_next;
    word_t   lstart_reg, lstart_next;
    word_t   lsize_reg, lsize_next;
    logic    rsp_valid_reg, rsp_valid_next;
    rsp_t    rsp_data_reg, rsp_data_next;

    logic    ram_we;
    idx_t    ram_waddr;
    region_t ram_wdata;
    idx_t    ram_raddr;
    logic [RW-1:0] ram_rdata;
    region_t rd;

    word_t   alu_a, alu_b, alu_diff;
    logic    alu_borrow;

    cnt_t    e_inc, e_dec, hi_dec, hi_dec2, count_dec;
    word_t   rem_start;
    logic    fin_go;

    bfa_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_cmp_sub u_cmp (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    assign rd        = region_t'(ram_rdata);
    assign e_inc     = e_reg + cnt_t'(1);
    assign e_dec     = e_reg - cnt_t'(1);
    assign hi_dec    = hi_reg - cnt_t'(1);
    assign hi_dec2   = hi_reg - cnt_t'(2);
    assign count_dec = count_reg - cnt_t'(1);
    assign rem_start = rd.start + amount_reg;
    assign fin_go    = (state_reg == S_FIN) && (!rsp_valid_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        alu_a = key_size_reg;
        alu_b = rd.size;
        if (state_reg == S_SCAN)
        begin
            alu_a = rd.size;
            alu_b = amount_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        amount_next    = amount_reg;
        key_size_next  = key_size_reg;
        key_start_next = key_start_reg;
        e_next         = e_reg;
        hi_next        = hi_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        lstart_next    = lstart_reg;
        lsize_next     = lsize_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = rd;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = (req.data.mode == MODE_ADD) ? count_dec[AW-1:0] : '0;
                if (req.valid)
                begin
                    mode_next      = req.data.mode;
                    amount_next    = req.data.amount;
                    key_size_next  = req.data.amount;
                    key_start_next = req.data.region_start;
                    status_next    = ST_OK;
                    granted_next   = '0;
                    lstart_next    = '0;
                    lsize_next     = '0;
                    e_next         = '0;
                    hi_next        = count_reg;
                    if (req.data.mode == MODE_ADD)
                    begin
                        if (count_reg == cnt_t'(MAX_REGIONS))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SIFT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_NOFIT;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                ram_raddr = e_inc[AW-1:0];
                if (!alu_borrow)
                begin
                    granted_next   = rd.start;
                    lstart_next    = rem_start;
                    lsize_next     = alu_diff;
                    key_size_next  = alu_diff;
                    key_start_next = rem_start;
                    if (alu_diff == '0 || amount_reg == '0)
                    begin
                        e_next     = e_inc;
                        state_next = S_REMOVE;
                    end
                    else
                    begin
                        hi_next    = e_reg;
                        state_next = S_SIFT_START;
                    end
                end
                else if (e_inc == count_reg)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_FIN;
                end
                else
                begin
                    e_next = e_inc;
                end
            end

            // close the gap left by an exact fit; lift a zero request past equal sizes
            S_REMOVE:
            begin
                ram_raddr = e_inc[AW-1:0];
                if (e_reg == count_reg || (lsize_reg != '0 && alu_borrow))
                begin
                    if (lsize_reg == '0)
                    begin
                        count_next = count_dec;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = e_dec[AW-1:0];
                        ram_wdata = '{size: key_size_reg, start: key_start_reg};
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = e_dec[AW-1:0];
                    e_next    = e_inc;
                end
            end

            S_SIFT_START:
            begin
                ram_raddr  = hi_dec[AW-1:0];
                state_next = S_SIFT;
            end

            // move larger entries up until the key finds its slot
            S_SIFT:
            begin
                ram_raddr = hi_dec2[AW-1:0];
                ram_we    = 1'b1;
                ram_waddr = hi_reg[AW-1:0];
                if ((hi_reg == '0) || !alu_borrow)
                begin
                    ram_wdata = '{size: key_size_reg, start: key_start_reg};
                    if (mode_reg == MODE_ADD)
                    begin
                        count_next = count_reg + cnt_t'(1);
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    hi_next = hi_dec;
                end
            end

            S_FIN:
            begin
                if (fin_go)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '{status:         status_reg,
                                       granted_start:  granted_reg,
                                       leftover_start: lstart_reg,
                                       leftover_size:  lsize_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_ADD;
            amount_reg    <= '0;
            key_size_reg  <= '0;
            key_start_reg <= '0;
            e_reg         <= '0;
            hi_reg        <= '0;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            granted_reg   <= '0;
            lstart_reg    <= '0;
            lsize_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            amount_reg    <= amount_next;
            key_size_reg  <= key_size_next;
            key_start_reg <= key_start_next;
            e_reg         <= e_next;
            hi_reg        <= hi_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            granted_reg   <= granted_next;
            lstart_reg    <= lstart_next;
            lsize_reg     <= lsize_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_REGIONS))
        else $error("region count above table depth");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_REMOVE || state_reg == S_SIFT))
        else $error("table write outside shift states");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.status != ST_OK) |->
            (rsp_data_reg.granted_start == '0 && rsp_data_reg.leftover_start == '0
             && rsp_data_reg.leftover_size == '0))
        else $error("failed beat carries nonzero fields");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT && state_next == S_FIN && mode_reg == MODE_ADD) |=>
            (count_reg == $past(count_reg) + cnt_t'(1)))
        else $error("successful add did not grow the table");

endmodule

`default_nettype wire
